>>> rtl/core/terminal_line_editor_macros.svh
// ----------------------------------------------------------------------------
// terminal_line_editor assertion macros
// Shorthand for clocked, reset-qualified assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_MACROS_SVH
`define TERMINAL_LINE_EDITOR_MACROS_SVH

// same-cycle implication
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared character codes, operation codes and interface structs of the
// terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TLD = 8'h7e;
    localparam logic [7:0] CH_DEL = 8'h7f;

    typedef logic [1:0] t_esc;
    localparam t_esc ESC_NONE    = 2'd0;
    localparam t_esc ESC_SEEN    = 2'd1;
    localparam t_esc ESC_BRACKET = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_BELL = 4'd1,
        OP_BACK = 4'd2,
        OP_FWD  = 4'd3,
        OP_HOME = 4'd4,
        OP_END  = 4'd5,
        OP_INS  = 4'd6,
        OP_DEL  = 4'd7,
        OP_EOL  = 4'd8
    } t_op;

    typedef struct packed {
        t_op  op;
        t_esc esc;
        logic pcr;
    } t_dec;

    // one result word toward the output stage, or a flush that marks the end
    typedef struct packed {
        logic       valid;
        logic       flush;
        logic       kind;
        logic [7:0] data;
    } t_emit;

endpackage

>>> rtl/core/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor
// Line editor for received terminal bytes with cursor, echo and line output.
// ----------------------------------------------------------------------------
// One received byte is taken while the block is idle (o_stall low); the block
// then stalls its input until every result word of that byte has entered the
// output register. Each result word and each line byte moved by an insert or
// delete is handled in turn: the line RAM has one port pair and the output
// register takes one word per cycle while i_stall is low. The costliest byte
// is a delete just after the first byte of a full line (61 words, 29 moves).
// Bytes that cause no result leave the block idle. Line storage needs no
// clearing after reset.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data
);

    logic  r_echo;
    logic  busy;
    logic  rdy;
    t_emit emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_echo <= i_cfg_wr_data;
        end
    end

    tle_seq #(.LINE_DEPTH(LINE_DEPTH)) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_rx_byte),
        .i_echo  (r_echo),
        .i_rdy   (rdy),
        .o_busy  (busy),
        .o_emit  (emit)
    );

    tle_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_stall (i_stall),
        .o_rdy   (rdy),
        .o_valid (o_valid),
        .o_kind  (o_out_kind),
        .o_byte  (o_out_byte),
        .o_last  (o_last)
    );

    assign o_stall = busy;

endmodule

>>> rtl/core/tle_decode.sv
// ----------------------------------------------------------------------------
// tle_decode
// Classifies a received byte against the escape and CR tracking state and
// the cursor position into one editing operation.
// ----------------------------------------------------------------------------
module tle_decode
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 32,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  logic [7:0]    i_byte,
    input  logic [AW-1:0] i_cur,
    input  logic [AW-1:0] i_len,
    input  logic          i_pcr,
    input  t_esc          i_esc,
    output t_dec          o_dec
);

    localparam logic [AW-1:0] FULL_LEN = AW'(LINE_DEPTH - 2);

    localparam logic [7:0] CH_CTRL_A = 8'h01;
    localparam logic [7:0] CH_CTRL_B = 8'h02;
    localparam logic [7:0] CH_CTRL_E = 8'h05;
    localparam logic [7:0] CH_CTRL_F = 8'h06;
    localparam logic [7:0] CH_CTRL_N = 8'h0e;
    localparam logic [7:0] CH_CTRL_P = 8'h10;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_LBRK   = 8'h5b;

    logic printable;
    t_op  back_op;
    t_op  fwd_op;

    assign printable = (i_byte >= CH_SP) && (i_byte <= CH_TLD);
    assign back_op   = (i_cur == '0) ? OP_BELL : OP_BACK;
    assign fwd_op    = (i_cur >= i_len) ? OP_BELL : OP_FWD;

    always_comb begin
        o_dec.op  = OP_NONE;
        o_dec.esc = ESC_NONE;
        o_dec.pcr = 1'b0;
        if (i_esc == ESC_BRACKET) begin
            if (i_byte == CH_UP || i_byte == CH_DOWN) begin
                o_dec.op = OP_BELL;
            end else if (i_byte == CH_RIGHT) begin
                o_dec.op = fwd_op;
            end else if (i_byte == CH_LEFT) begin
                o_dec.op = back_op;
            end
        end else begin
            o_dec.pcr = (i_byte == CH_CR);
            o_dec.esc = (i_byte == CH_ESC) ? ESC_SEEN : ESC_NONE;
            if (printable) begin
                if (i_esc == ESC_SEEN && i_byte == CH_LBRK) begin
                    o_dec.esc = ESC_BRACKET;
                end else begin
                    o_dec.op = (i_len >= FULL_LEN) ? OP_BELL : OP_INS;
                end
            end else if (i_pcr && (i_byte == CH_LF || i_byte == CH_NUL)) begin
                o_dec.op = OP_NONE;
            end else if (i_byte == CH_LF || i_byte == CH_CR) begin
                o_dec.op = OP_EOL;
            end else if (i_byte == CH_DEL) begin
                o_dec.op = (i_cur == '0) ? OP_BELL : OP_DEL;
            end else if (i_byte == CH_CTRL_B) begin
                o_dec.op = back_op;
            end else if (i_byte == CH_CTRL_F) begin
                o_dec.op = fwd_op;
            end else if (i_byte == CH_CTRL_A) begin
                o_dec.op = (i_cur != '0) ? OP_HOME : OP_NONE;
            end else if (i_byte == CH_CTRL_E) begin
                o_dec.op = (i_cur < i_len) ? OP_END : OP_NONE;
            end else if (i_byte == CH_CTRL_P || i_byte == CH_CTRL_N) begin
                o_dec.op = OP_BELL;
            end
        end
    end

endmodule

>>> rtl/core/tle_seq.sv
// ----------------------------------------------------------------------------
// tle_seq
// Line RAM and the sequencer that shifts it, writes new bytes and walks it
// to produce echo and line words, one word per cycle while the output is ready.
// ----------------------------------------------------------------------------
module tle_seq
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 32,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_echo,
    input  logic       i_rdy,
    output logic       o_busy,
    output t_emit      o_emit
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COPY  = 7'b0000010,
        S_WCHR  = 7'b0000100,
        S_CHR   = 7'b0001000,
        S_MEMO  = 7'b0010000,
        S_REP   = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    localparam logic [AW-1:0] ONE = AW'(1);

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [AW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_len, n_len;
    logic          r_pcr, n_pcr;
    t_esc          r_esc, n_esc;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_chr, n_chr;
    logic          r_kind, n_kind;
    logic [7:0]    r_rdata;
    logic [7:0]    mem [LINE_DEPTH];

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    t_dec          dec;

    tle_decode #(.LINE_DEPTH(LINE_DEPTH)) u_decode (
        .i_byte (i_byte),
        .i_cur  (r_cur),
        .i_len  (r_len),
        .i_pcr  (r_pcr),
        .i_esc  (r_esc),
        .o_dec  (dec)
    );

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cur   = r_cur;
        n_len   = r_len;
        n_pcr   = r_pcr;
        n_esc   = r_esc;
        n_ptr   = r_ptr;
        n_cnt   = r_cnt;
        n_chr   = r_chr;
        n_kind  = r_kind;
        we      = 1'b0;
        waddr   = r_cur;
        wdata   = r_rdata;
        o_emit  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_esc  = dec.esc;
                    n_pcr  = dec.pcr;
                    n_op   = dec.op;
                    n_kind = 1'b0;
                    case (dec.op)
                        OP_NONE: begin
                            n_state = S_IDLE;
                        end
                        OP_BELL: begin
                            n_chr   = CH_BEL;
                            n_state = S_CHR;
                        end
                        OP_BACK: begin
                            n_chr   = CH_BS;
                            n_cur   = r_cur - ONE;
                            n_state = S_CHR;
                        end
                        OP_FWD: begin
                            n_ptr   = r_cur;
                            n_cnt   = ONE;
                            n_cur   = r_cur + ONE;
                            n_state = S_MEMO;
                        end
                        OP_HOME: begin
                            n_chr   = CH_BS;
                            n_cnt   = r_cur;
                            n_cur   = '0;
                            n_state = S_REP;
                        end
                        OP_END: begin
                            n_ptr   = r_cur;
                            n_cnt   = r_len - r_cur;
                            n_cur   = r_len;
                            n_state = S_MEMO;
                        end
                        OP_INS: begin
                            n_chr = i_byte;
                            if (r_len != r_cur) begin
                                n_ptr   = r_len - ONE;
                                n_cnt   = r_len - r_cur;
                                n_state = S_COPY;
                            end else begin
                                n_state = S_WCHR;
                            end
                        end
                        OP_DEL: begin
                            n_chr   = CH_BS;
                            n_ptr   = r_cur;
                            n_cur   = r_cur - ONE;
                            n_len   = r_len - ONE;
                            n_state = S_CHR;
                        end
                        OP_EOL: begin
                            n_chr   = CH_LF;
                            n_state = S_CHR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY: begin
                we    = 1'b1;
                wdata = r_rdata;
                n_cnt = r_cnt - ONE;
                if (r_op == OP_INS) begin
                    waddr = r_ptr + ONE;
                    n_ptr = r_ptr - ONE;
                end else begin
                    waddr = r_ptr - ONE;
                    n_ptr = r_ptr + ONE;
                end
                if (r_cnt == ONE) begin
                    if (r_op == OP_INS) begin
                        n_ptr   = r_cur;
                        n_state = S_WCHR;
                    end else if (i_echo) begin
                        n_ptr   = r_cur;
                        n_cnt   = r_len - r_cur;
                        n_state = S_MEMO;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_WCHR: begin
                we      = 1'b1;
                waddr   = r_cur;
                wdata   = r_chr;
                n_cur   = r_cur + ONE;
                n_len   = r_len + ONE;
                n_ptr   = r_cur + ONE;
                n_state = i_echo ? S_CHR : S_FLUSH;
            end
            S_CHR: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = r_kind;
                o_emit.data  = r_chr;
                if (i_rdy) begin
                    n_state = S_FLUSH;
                    case (r_op)
                        OP_INS: begin
                            if (r_len != r_cur) begin
                                n_cnt   = r_len - r_cur;
                                n_state = S_MEMO;
                            end
                        end
                        OP_DEL: begin
                            if (r_chr == CH_BS) begin
                                if (r_len != r_cur) begin
                                    n_cnt   = r_len - r_cur;
                                    n_state = S_COPY;
                                end else if (i_echo) begin
                                    n_chr   = CH_SP;
                                    n_state = S_CHR;
                                end
                            end else begin
                                n_chr   = CH_BS;
                                n_cnt   = r_len - r_cur + ONE;
                                n_state = S_REP;
                            end
                        end
                        OP_EOL: begin
                            if (!r_kind && r_chr == CH_LF) begin
                                n_chr   = CH_CR;
                                n_state = S_CHR;
                            end else if (!r_kind) begin
                                n_kind = 1'b1;
                                if (r_len != '0) begin
                                    n_ptr   = '0;
                                    n_cnt   = r_len;
                                    n_state = S_MEMO;
                                end else begin
                                    n_chr   = CH_LF;
                                    n_state = S_CHR;
                                end
                            end else begin
                                n_len = '0;
                                n_cur = '0;
                            end
                        end
                        default: begin
                            n_state = S_FLUSH;
                        end
                    endcase
                end
            end
            S_MEMO: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = r_kind;
                o_emit.data  = r_rdata;
                if (i_rdy) begin
                    n_ptr = r_ptr + ONE;
                    n_cnt = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        case (r_op)
                            OP_INS: begin
                                n_chr   = CH_BS;
                                n_cnt   = r_len - r_cur;
                                n_state = S_REP;
                            end
                            OP_DEL: begin
                                n_chr   = CH_SP;
                                n_state = S_CHR;
                            end
                            OP_EOL: begin
                                n_chr   = CH_LF;
                                n_state = S_CHR;
                            end
                            default: begin
                                n_state = S_FLUSH;
                            end
                        endcase
                    end
                end
            end
            S_REP: begin
                o_emit.valid = 1'b1;
                o_emit.kind  = 1'b0;
                o_emit.data  = r_chr;
                if (i_rdy) begin
                    n_cnt = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                o_emit.valid = 1'b1;
                o_emit.flush = 1'b1;
                if (i_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
            r_cur   <= '0;
            r_len   <= '0;
            r_pcr   <= 1'b0;
            r_esc   <= ESC_NONE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cur   <= n_cur;
            r_len   <= n_len;
            r_pcr   <= n_pcr;
            r_esc   <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_chr  <= n_chr;
        r_kind <= n_kind;
    end

    // line RAM, read data forwarded on a same-address write
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= (we && waddr == n_ptr) ? wdata : mem[n_ptr];
    end

endmodule

>>> rtl/core/tle_out.sv
// ----------------------------------------------------------------------------
// tle_out
// Result output stage: a holding word that learns whether it is the last of
// its byte, and the registered output word behind it.
// ----------------------------------------------------------------------------
module tle_out
    import tle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_emit      i_emit,
    input  logic       i_stall,
    output logic       o_rdy,
    output logic       o_valid,
    output logic       o_kind,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_hvalid;
    logic       r_hkind;
    logic [7:0] r_hbyte;
    logic       r_ovalid;
    logic       r_okind;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic out_free;
    logic take;
    logic push_out;

    assign out_free = !r_ovalid || !i_stall;
    assign o_rdy    = !r_hvalid || out_free;
    assign take     = i_emit.valid && o_rdy;
    assign push_out = take && r_hvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_hvalid <= 1'b0;
        end else begin
            if (push_out) begin
                r_ovalid <= 1'b1;
            end else if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (take) begin
                r_hvalid <= !i_emit.flush;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_okind <= r_hkind;
            r_obyte <= r_hbyte;
            r_olast <= i_emit.flush;
        end
        if (take && !i_emit.flush) begin
            r_hkind <= i_emit.kind;
            r_hbyte <= i_emit.data;
        end
    end

    assign o_valid = r_ovalid;
    assign o_kind  = r_okind;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

endmodule

>>> rtl/core/tle_checker.sv
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks of the line editor, bound to the top level.
// ----------------------------------------------------------------------------
`include "terminal_line_editor_macros.svh"

module tle_checker
    import tle_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    `TLE_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_out_kind) && $stable(o_last), "stalled output word changed")

    `TLE_ASSERT_NOW(a_bell_alone, o_valid && !o_out_kind && o_out_byte == CH_BEL, o_last, "bell not the only word of its byte")

    `TLE_ASSERT_NOW(a_line_ends_lf, o_valid && o_out_kind && o_last, o_out_byte == CH_LF, "completed line not ended by newline")

    `TLE_ASSERT_NOW(a_echo_legal, o_valid && !o_out_kind, (o_out_byte >= CH_SP && o_out_byte <= CH_TLD) || o_out_byte == CH_BEL || o_out_byte == CH_BS || o_out_byte == CH_LF || o_out_byte == CH_CR, "echo word is an unexpected control byte")

endmodule

bind terminal_line_editor tle_checker u_chk (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// terminal_line_editor testbench
// Feeds received terminal bytes (directed edits, escape sequences, line ends,
// full-line bursts and random noise) under random valid/stall gaps, predicts
// every echo and line word from a local copy of the editor state, and checks
// each output word in order. The echo register is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tle_pkg::*;

    localparam int LINE_DEPTH   = 32;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_MARK   = -1;
    localparam int SETTLE_IDLE  = 8;
    localparam int SETTLE_END   = 120;

    localparam logic [7:0] CTRL_A    = 8'h01;
    localparam logic [7:0] CTRL_B    = 8'h02;
    localparam logic [7:0] CTRL_E    = 8'h05;
    localparam logic [7:0] CTRL_F    = 8'h06;
    localparam logic [7:0] CTRL_N    = 8'h0e;
    localparam logic [7:0] CTRL_P    = 8'h10;
    localparam logic [7:0] SEQ_CSI   = "[";
    localparam logic [7:0] SEQ_UP    = "A";
    localparam logic [7:0] SEQ_DOWN  = "B";
    localparam logic [7:0] SEQ_RIGHT = "C";
    localparam logic [7:0] SEQ_LEFT  = "D";

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_out_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic       o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;

    int        pending_bytes[$];
    t_out_word expected_words[$];
    bit        rx_taken;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        error_count;
    int        cycle_count;

    // editor state as the block should hold it
    logic [7:0] line_buf [LINE_DEPTH];
    int         cur_pos;
    int         line_len;
    bit         prev_cr;
    t_esc       esc_state;
    bit         echo_on;

    logic [7:0] directed_bytes [30] = '{
        "a", CH_TLD, CTRL_B, CH_SP, CH_DEL, CTRL_A, CH_DEL, CTRL_B, CTRL_E, CTRL_F,
        CH_ESC, SEQ_CSI, SEQ_LEFT, CH_ESC, SEQ_CSI, SEQ_RIGHT,
        CH_ESC, SEQ_CSI, SEQ_UP, CH_ESC, SEQ_CSI, CH_CR,
        CTRL_N, CH_ESC, "x", 8'hff, CH_CR, CH_LF, CH_CR, CH_NUL
    };

    terminal_line_editor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void push_word(logic kind, logic [7:0] data);
        t_out_word w;
        w.kind = kind;
        w.data = data;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void step_back();
        if (cur_pos == 0) begin
            push_word(1'b0, CH_BEL);
        end else begin
            push_word(1'b0, CH_BS);
            cur_pos--;
        end
    endfunction

    function automatic void step_forward();
        if (cur_pos >= line_len) begin
            push_word(1'b0, CH_BEL);
        end else begin
            push_word(1'b0, line_buf[cur_pos]);
            cur_pos++;
        end
    endfunction

    function automatic void apply_rx_byte(logic [7:0] c);
        int        first;
        int        i;
        bit        was_cr;
        bit        was_esc;
        t_out_word tail;
        first   = expected_words.size();
        was_cr  = prev_cr;
        was_esc = (esc_state == ESC_SEEN);
        if (esc_state == ESC_BRACKET) begin
            esc_state = ESC_NONE;
            prev_cr   = 1'b0;
            if (c == SEQ_UP || c == SEQ_DOWN) begin
                push_word(1'b0, CH_BEL);
            end else if (c == SEQ_RIGHT) begin
                step_forward();
            end else if (c == SEQ_LEFT) begin
                step_back();
            end
        end else begin
            prev_cr   = (c == CH_CR);
            esc_state = (c == CH_ESC) ? ESC_SEEN : ESC_NONE;
            if (c >= CH_SP && c <= CH_TLD) begin
                if (was_esc && c == SEQ_CSI) begin
                    esc_state = ESC_BRACKET;
                    prev_cr   = 1'b0;
                end else if (line_len >= LINE_DEPTH - 2) begin
                    push_word(1'b0, CH_BEL);
                end else begin
                    for (i = line_len; i > cur_pos; i--)
                        line_buf[i] = line_buf[i-1];
                    line_buf[cur_pos] = c;
                    cur_pos++;
                    line_len++;
                    if (echo_on) begin
                        for (i = cur_pos - 1; i < line_len; i++)
                            push_word(1'b0, line_buf[i]);
                        for (i = cur_pos; i < line_len; i++)
                            push_word(1'b0, CH_BS);
                    end
                end
            end else if (was_cr && (c == CH_LF || c == CH_NUL)) begin
                // tail of a CR-LF or CR-NUL pair
            end else if (c == CH_LF || c == CH_CR) begin
                push_word(1'b0, CH_LF);
                push_word(1'b0, CH_CR);
                for (i = 0; i < line_len; i++)
                    push_word(1'b1, line_buf[i]);
                push_word(1'b1, CH_LF);
                line_len = 0;
                cur_pos  = 0;
            end else if (c == CH_DEL) begin
                if (cur_pos == 0) begin
                    push_word(1'b0, CH_BEL);
                end else begin
                    push_word(1'b0, CH_BS);
                    line_len--;
                    cur_pos--;
                    for (i = cur_pos; i < line_len; i++)
                        line_buf[i] = line_buf[i+1];
                    if (echo_on) begin
                        for (i = cur_pos; i < line_len; i++)
                            push_word(1'b0, line_buf[i]);
                        push_word(1'b0, CH_SP);
                        for (i = cur_pos; i <= line_len; i++)
                            push_word(1'b0, CH_BS);
                    end
                end
            end else if (c == CTRL_B) begin
                step_back();
            end else if (c == CTRL_F) begin
                step_forward();
            end else if (c == CTRL_A) begin
                while (cur_pos != 0) begin
                    push_word(1'b0, CH_BS);
                    cur_pos--;
                end
            end else if (c == CTRL_E) begin
                while (cur_pos < line_len) begin
                    push_word(1'b0, line_buf[cur_pos]);
                    cur_pos++;
                end
            end else if (c == CTRL_P || c == CTRL_N) begin
                push_word(1'b0, CH_BEL);
            end
        end
        if (expected_words.size() > first) begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endfunction

    task automatic queue_random_bytes(int count);
        int added;
        int pick;
        int n;
        logic [7:0] edit_keys [8];
        edit_keys = '{CTRL_A, CTRL_B, CTRL_E, CTRL_F, CH_DEL, CH_DEL, CTRL_P, CTRL_N};
        added = 0;
        while (added < count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                pending_bytes.push_back($urandom_range(CH_SP, CH_TLD));
                added += 1;
            end else if (pick < 55) begin
                pending_bytes.push_back(edit_keys[$urandom_range(7)]);
                added += 1;
            end else if (pick < 67) begin
                pending_bytes.push_back(CH_ESC);
                pending_bytes.push_back(SEQ_CSI);
                if ($urandom_range(4) == 0)
                    pending_bytes.push_back($urandom_range(255));
                else
                    pending_bytes.push_back(SEQ_UP + $urandom_range(3));
                added += 3;
            end else if (pick < 70) begin
                pending_bytes.push_back(CH_ESC);
                pending_bytes.push_back($urandom_range(255));
                added += 2;
            end else if (pick < 80) begin
                pending_bytes.push_back($urandom_range(1) ? CH_CR : CH_LF);
                if ($urandom_range(1))
                    pending_bytes.push_back($urandom_range(1) ? CH_LF : CH_NUL);
                added += 2;
            end else if (pick < 92) begin
                pending_bytes.push_back($urandom_range(255));
                added += 1;
            end else begin
                // run the line toward the full limit, then edit at its head
                n = $urandom_range(26, 34);
                repeat (n) pending_bytes.push_back($urandom_range(CH_SP, CH_TLD));
                pending_bytes.push_back(CTRL_A);
                pending_bytes.push_back(CTRL_F);
                pending_bytes.push_back(CH_DEL);
                pending_bytes.push_back($urandom_range(CH_SP, CH_TLD));
                pending_bytes.push_back(CH_CR);
                added += n + 5;
            end
        end
    endtask

    task automatic wait_drained(int settle);
        while (pending_bytes.size() != 0 || (i_valid && !rx_taken) ||
               expected_words.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_echo(bit value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        echo_on = value;
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !rx_taken) begin
            // hold the word until taken
        end else begin
            rx_taken = 1'b0;
            if (pending_bytes.size() > 0 && pending_bytes[0] == DRAIN_MARK &&
                expected_words.size() == 0)
                void'(pending_bytes.pop_front());
            if (pending_bytes.size() > 0 && pending_bytes[0] != DRAIN_MARK &&
                $urandom_range(99) >= send_idle_pct) begin
                i_valid   <= 1'b1;
                i_rx_byte <= 8'(pending_bytes.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        i_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            rx_taken = 1'b1;
            apply_rx_byte(i_rx_byte);
        end
    end

    always @(posedge i_clk) begin : out_check
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind=%0d byte=%h last=%0d",
                                          o_out_kind, o_out_byte, o_last));
            end else begin
                want = expected_words.pop_front();
                if (o_out_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_out_kind, want.kind));
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("byte %h, want %h", o_out_byte, want.data));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", o_last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("terminal_line_editor regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rx_byte     = 8'h00;
        i_stall       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        rx_taken      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        cur_pos       = 0;
        line_len      = 0;
        prev_cr       = 1'b0;
        esc_state     = ESC_NONE;
        echo_on       = 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 60;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[k])
            pending_bytes.push_back(directed_bytes[k]);
        queue_random_bytes(80);
        wait_drained(SETTLE_IDLE);

        write_echo(1'b0);
        send_idle_pct = 60;
        recv_idle_pct = 20;
        queue_random_bytes(35);
        pending_bytes.push_back(DRAIN_MARK);
        queue_random_bytes(35);
        wait_drained(SETTLE_IDLE);

        write_echo(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_bytes(80);
        wait_drained(SETTLE_END);

        if (error_count == 0)
            $display("terminal_line_editor regression: pass");
        else
            $display("terminal_line_editor regression: fail");
        $finish;
    end

endmodule
